// File: hw/rtl/fdls_pkg.sv
// Shared constants, types and register codes for the smoothed fractional delay line.
// No dependencies; imported by every module of the block but the generic RAM.
package fdls_pkg;

  localparam int BUFFER_DEPTH  = 65536;
  localparam int FRACTION_BITS = 16;
  localparam int SAMPLE_BITS   = 24;

  localparam int ADDR_BITS  = $clog2(BUFFER_DEPTH);
  localparam int DELAY_BITS = 32;
  localparam int COEF_BITS  = 16;
  localparam int POS_BITS   = ADDR_BITS + FRACTION_BITS;
  localparam int CALC_BITS  = DELAY_BITS + 1;

  // Delay span of the whole store, and the first target value that is refused.
  localparam logic [CALC_BITS-1:0] SPAN = CALC_BITS'(BUFFER_DEPTH) << FRACTION_BITS;
  localparam logic [CALC_BITS-1:0] TARGET_LIMIT =
    CALC_BITS'(BUFFER_DEPTH - 1) << FRACTION_BITS;

  localparam logic [COEF_BITS-1:0] RATE_RESET   = COEF_BITS'(66);
  localparam logic [COEF_BITS-1:0] THRESH_RESET = COEF_BITS'(655);

  localparam int FIFO_DEPTH    = 4;
  localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
  localparam int CNT_BITS      = $clog2(FIFO_DEPTH + 1);

  localparam int PADDR_BITS = 4;
  localparam int PDATA_BITS = 32;

  typedef logic [ADDR_BITS-1:0]          addr_t;
  typedef logic [DELAY_BITS-1:0]         delay_t;
  typedef logic [COEF_BITS-1:0]          coef_t;
  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  // Register map, word index = paddr[3:2]
  typedef enum logic [1:0] {
    REG_TARGET = 2'd0,
    REG_RATE   = 2'd1,
    REG_THRESH = 2'd2
  } reg_idx_t;

  // Read-side control of one beat: write slot it used and whether the store had wrapped.
  typedef struct packed {
    logic  valid;
    addr_t wp;
    logic  full;
  } rd_ctl_t;

endpackage

// File: hw/rtl/fdls_ram.sv
// Generic simple RAM: one write port, two read ports, registered read data.
// Standalone; used for the sample store.
module fdls_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// File: hw/rtl/fdls_glide.sv
// One-pole glide of the current delay toward the target, with snap.
// Depends on fdls_pkg. Update in order: difference, then multiply and apply.
module fdls_glide import fdls_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   start,
  input  delay_t target,
  input  coef_t  rate,
  input  coef_t  thresh,
  output delay_t cur_delay
);

  logic   upd;
  delay_t mag;
  logic   up;
  logic   ne;
  logic   snap;

  logic                           up_c;
  delay_t                         mag_c;
  logic [DELAY_BITS+COEF_BITS-1:0] prod;
  delay_t                         step;
  delay_t                         cur_next;

  always_comb begin
    up_c  = target > cur_delay;
    mag_c = up_c ? target - cur_delay : cur_delay - target;
  end

  always_comb begin
    prod = (DELAY_BITS + COEF_BITS)'(mag) * (DELAY_BITS + COEF_BITS)'(rate);
    step = prod[DELAY_BITS+COEF_BITS-1:COEF_BITS];
    if (!ne) begin
      cur_next = cur_delay;
    end else if (snap) begin
      cur_next = target;
    end else if (up) begin
      cur_next = cur_delay + step;
    end else begin
      cur_next = cur_delay - step;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upd       <= 1'b0;
      cur_delay <= '0;
    end else begin
      upd <= start;
      if (upd) begin
        cur_delay <= cur_next;
      end
    end
  end

  // snap compares the difference before the step is taken
  always_ff @(posedge clk) begin
    if (start) begin
      mag  <= mag_c;
      up   <= up_c;
      ne   <= target != cur_delay;
      snap <= mag_c < DELAY_BITS'(thresh);
    end
  end

endmodule

// File: hw/rtl/fdls_interp.sv
// Read position, store read addresses and linear interpolation.
// Depends on fdls_pkg; drives the two read ports of the sample store.
module fdls_interp import fdls_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  rd_ctl_t ctl,
  input  delay_t  cur_delay,
  output addr_t   raddr_a,
  output addr_t   raddr_b,
  input  sample_t rdata_a,
  input  sample_t rdata_b,
  output logic    res_valid,
  output sample_t res_sample
);

  localparam int PROD_BITS = FRACTION_BITS + SAMPLE_BITS + 2;

  logic [CALC_BITS-1:0]     pos_raw;
  logic [CALC_BITS-1:0]     pos_wrap;
  logic [POS_BITS-1:0]      pos;
  addr_t                    idx;
  addr_t                    nxt;
  logic [FRACTION_BITS-1:0] frac_c;

  logic                     v3;
  logic [FRACTION_BITS-1:0] frac3;
  logic                     ok1;
  logic                     ok2;

  sample_t                        s1;
  sample_t                        s2;
  logic signed [SAMPLE_BITS:0]    diff;
  logic signed [PROD_BITS-1:0]    prod_c;

  logic                        v4;
  sample_t                     s1_4;
  logic signed [PROD_BITS-1:0] prod4;
  logic signed [PROD_BITS-1:0] shifted;

  // pos = wp - delay, wrapped into the span
  always_comb begin
    pos_raw  = CALC_BITS'({ctl.wp, {FRACTION_BITS{1'b0}}}) - CALC_BITS'(cur_delay);
    pos_wrap = pos_raw[CALC_BITS-1] ? pos_raw + SPAN : pos_raw;
    pos      = pos_wrap[POS_BITS-1:0];
    idx      = pos[POS_BITS-1:FRACTION_BITS];
    frac_c   = pos[FRACTION_BITS-1:0];
    nxt      = (idx == ADDR_BITS'(BUFFER_DEPTH - 1)) ? '0 : idx + 1'b1;
  end

  assign raddr_a = idx;
  assign raddr_b = nxt;

  // Entries not yet written since reset read as zero: written are 0..wp until the first wrap.
  always_ff @(posedge clk) begin
    frac3 <= frac_c;
    ok1   <= ctl.full || (idx <= ctl.wp);
    ok2   <= ctl.full || (nxt <= ctl.wp);
  end

  always_comb begin
    s1     = ok1 ? rdata_a : '0;
    s2     = ok2 ? rdata_b : '0;
    diff   = (SAMPLE_BITS + 1)'(s2) - (SAMPLE_BITS + 1)'(s1);
    prod_c = PROD_BITS'($signed({1'b0, frac3})) * PROD_BITS'(diff);
  end

  always_ff @(posedge clk) begin
    s1_4  <= s1;
    prod4 <= prod_c;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v3 <= ctl.valid;
      v4 <= v3;
    end
  end

  // floor division by 2^F, then add; result lies between s1 and s2
  assign shifted    = prod4 >>> FRACTION_BITS;
  assign res_valid  = v4;
  assign res_sample = s1_4 + shifted[SAMPLE_BITS-1:0];

endmodule

// File: hw/rtl/fdls_out_fifo.sv
// Small output queue that holds finished results until the sink takes them.
// Depends on fdls_pkg.
module fdls_out_fifo import fdls_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  sample_t push_data,
  input  logic    pop,
  output logic    out_valid,
  output sample_t out_data
);

  sample_t                  mem [FIFO_DEPTH];
  logic [FIFO_PTR_BITS-1:0] wr_ptr;
  logic [FIFO_PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0]      count;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  assign out_valid = count != '0;
  assign out_data  = mem[rd_ptr];

endmodule

// File: hw/rtl/fractional_delay_line_smoothed_core.sv
// Channel   Dir  Payload                         Handshake
// s_axis    in   tdata[23:0] in_sample           tvalid/tready
// m_axis    out  tdata[23:0] out_sample          tvalid/tready
// apb       in   target/rate/threshold at 0,4,8  psel/penable/pready
//
// A beat is taken only once the glide loop on the current delay (difference,
// then multiply and apply) has updated for the previous one. m_axis_tvalid
// rises once a beat has passed st1, st2, the store read and the product
// register into the output queue. Synchronous reset; no clearing pass, a fill
// mark makes unwritten store entries read as zero. Output back-pressure is
// absorbed by a 4-deep queue; input stalls once 4 beats are outstanding.
// Top level; depends on fdls_pkg, fdls_ram, fdls_glide, fdls_interp, fdls_out_fifo.
module fractional_delay_line_smoothed_core import fdls_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [23:0]           s_axis_tdata,   // [23:0] in_sample
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [23:0]           m_axis_tdata,   // [23:0] out_sample
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_BITS-1:0] paddr,
  input  logic [PDATA_BITS-1:0] pwdata,
  output logic [PDATA_BITS-1:0] prdata,
  output logic                  pready
);

  delay_t target;
  coef_t  rate;
  coef_t  thresh;

  addr_t               wp;
  logic                full;
  rd_ctl_t             st1;
  rd_ctl_t             st2;
  logic [CNT_BITS-1:0] outstanding;

  logic    in_acc;
  logic    out_acc;
  logic    cfg_wr;
  delay_t  cur_delay;
  addr_t   raddr_a;
  addr_t   raddr_b;
  sample_t rdata_a;
  sample_t rdata_b;
  logic    res_valid;
  sample_t res_sample;
  sample_t out_data;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      target <= '0;
      rate   <= RATE_RESET;
      thresh <= THRESH_RESET;
    end else if (cfg_wr) begin
      unique case (reg_idx_t'(paddr[3:2]))
        REG_TARGET: begin
          if (CALC_BITS'(pwdata) < TARGET_LIMIT) begin
            target <= pwdata;
          end
        end
        REG_RATE:   rate   <= pwdata[COEF_BITS-1:0];
        REG_THRESH: thresh <= pwdata[COEF_BITS-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_t'(paddr[3:2]))
      REG_TARGET: prdata = target;
      REG_RATE:   prdata = PDATA_BITS'(rate);
      REG_THRESH: prdata = PDATA_BITS'(thresh);
      default:    prdata = '0;
    endcase
  end

  // next beat waits for the delay update of the previous one
  assign s_axis_tready = !st1.valid && (outstanding < CNT_BITS'(FIFO_DEPTH));
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_acc       = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp          <= '0;
      full        <= 1'b0;
      st1         <= '0;
      st2         <= '0;
      outstanding <= '0;
    end else begin
      st1 <= '{valid: in_acc, wp: wp, full: full};
      st2 <= st1;
      if (in_acc) begin
        wp <= (wp == ADDR_BITS'(BUFFER_DEPTH - 1)) ? '0 : wp + 1'b1;
        if (wp == ADDR_BITS'(BUFFER_DEPTH - 1)) begin
          full <= 1'b1;
        end
      end
      case ({in_acc, out_acc})
        2'b10:   outstanding <= outstanding + 1'b1;
        2'b01:   outstanding <= outstanding - 1'b1;
        default: outstanding <= outstanding;
      endcase
    end
  end

  fdls_ram #(
    .WIDTH(SAMPLE_BITS),
    .DEPTH(BUFFER_DEPTH)
  ) u_store (
    .clk     (clk),
    .we      (in_acc),
    .waddr   (wp),
    .wdata   (s_axis_tdata),
    .raddr_a (raddr_a),
    .rdata_a (rdata_a),
    .raddr_b (raddr_b),
    .rdata_b (rdata_b)
  );

  fdls_glide u_glide (
    .clk       (clk),
    .rst       (rst),
    .start     (in_acc),
    .target    (target),
    .rate      (rate),
    .thresh    (thresh),
    .cur_delay (cur_delay)
  );

  fdls_interp u_interp (
    .clk        (clk),
    .rst        (rst),
    .ctl        (st2),
    .cur_delay  (cur_delay),
    .raddr_a    (raddr_a),
    .raddr_b    (raddr_b),
    .rdata_a    (rdata_a),
    .rdata_b    (rdata_b),
    .res_valid  (res_valid),
    .res_sample (res_sample)
  );

  fdls_out_fifo u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res_sample),
    .pop       (out_acc),
    .out_valid (m_axis_tvalid),
    .out_data  (out_data)
  );

  assign m_axis_tdata = out_data;

endmodule

// File: tb/testbench.sv
// Self-checking bench for the smoothed fractional delay line core.
// Holds a scoreboard class with its own delay-line predictor; needs fdls_pkg and the RTL.
`timescale 1ns / 1ps

module testbench;
  import fdls_pkg::*;

  localparam int          ITEMS       = 1150;
  localparam int          CYCLE_LIMIT = 400000;
  localparam logic [1:0]  REG_SPARE   = 2'd3;

  // Tracks glide, store and write slot; predicts one out_sample per input beat.
  class fdl_tracker;
    sample_t store [BUFFER_DEPTH];
    addr_t   wr_ptr;
    delay_t  cur_delay;
    delay_t  tgt_delay;
    coef_t   rate;
    coef_t   thresh;
    sample_t pending_out [$];
    int      errors;

    function new();
      foreach (store[i]) store[i] = '0;
      wr_ptr    = '0;
      cur_delay = '0;
      tgt_delay = '0;
      rate      = RATE_RESET;
      thresh    = THRESH_RESET;
      errors    = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        REG_TARGET: if ({1'b0, val} < TARGET_LIMIT) tgt_delay = val;
        REG_RATE:   rate = val[COEF_BITS-1:0];
        REG_THRESH: thresh = val[COEF_BITS-1:0];
        default: ;
      endcase
    endfunction

    function void accept_sample(sample_t s);
      logic [32:0]        gap_mag;
      logic [48:0]        prod;
      logic [31:0]        step;
      logic               up;
      logic [31:0]        pos;
      addr_t              idx;
      addr_t              nxt;
      logic signed [16:0] frac;
      sample_t            s1;
      sample_t            s2;
      logic signed [24:0] diff;
      logic signed [41:0] term;
      sample_t            res;
      store[wr_ptr] = s;
      if (cur_delay != tgt_delay) begin
        up      = tgt_delay > cur_delay;
        gap_mag = up ? {1'b0, tgt_delay} - {1'b0, cur_delay}
                     : {1'b0, cur_delay} - {1'b0, tgt_delay};
        prod = gap_mag * rate;
        step = prod[47:16];
        cur_delay = up ? cur_delay + step : cur_delay - step;
        // snap decision uses the distance before the step
        if (gap_mag < {17'b0, thresh}) cur_delay = tgt_delay;
      end
      // span of the store is 2^32 in 16.16, so the wrap is plain 32-bit math
      pos  = {wr_ptr, {FRACTION_BITS{1'b0}}} - cur_delay;
      idx  = pos[31:16];
      nxt  = idx + 1'b1;
      frac = $signed({1'b0, pos[15:0]});
      s1   = store[idx];
      s2   = store[nxt];
      diff = s2 - s1;
      term = frac * diff;
      res  = s1 + (term >>> FRACTION_BITS);
      pending_out.push_back(res);
      wr_ptr = wr_ptr + 1'b1;
    endfunction

    function void match_output(sample_t got);
      sample_t want;
      if (pending_out.size() == 0) begin
        $display("%0t: out_sample with nothing pending: expected none, actual %h",
                 $time, got);
        errors++;
        return;
      end
      want = pending_out.pop_front();
      if (got !== want) begin
        $display("%0t: out_sample mismatch: expected %h, actual %h", $time, want, got);
        errors++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [23:0]           s_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [23:0]           m_axis_tdata;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [PADDR_BITS-1:0] paddr;
  logic [PDATA_BITS-1:0] pwdata;
  logic [PDATA_BITS-1:0] prdata;
  logic                  pready;

  fdl_tracker sb;
  bit         src_steady;
  bit         sink_steady;

  fractional_delay_line_smoothed_core u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  function automatic int src_gap();
    if (src_steady || $urandom_range(0, 99) < 45) return 0;
    return pick_gap();
  endfunction

  function automatic sample_t rand_sample();
    case ($urandom_range(0, 39))
      0:       return 24'h7FFFFF;
      1:       return 24'h800000;
      2:       return 24'h000000;
      3:       return 24'hFFFFFF;
      default: return sample_t'($urandom);
    endcase
  endfunction

  always @(posedge clk) begin
    if (!rst && s_axis_tvalid && s_axis_tready) sb.accept_sample(s_axis_tdata);
    if (!rst && m_axis_tvalid && m_axis_tready) sb.match_output(m_axis_tdata);
  end

  // output side back-pressure
  initial begin
    int stall_left;
    stall_left    = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (rst) begin
        m_axis_tready <= 1'b0;
      end else if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
        if (!sink_steady && $urandom_range(0, 99) < 35) stall_left = pick_gap();
      end
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Verification failed");
    $finish;
  end

  // one input beat; tvalid stays up across back-to-back beats
  task automatic send_sample(sample_t val, int gap);
    @(negedge clk);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= val;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // stop the stream and wait until every predicted sample has come out
  task automatic drain_results();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (sb.pending_out.size() != 0) @(posedge clk);
  endtask

  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.write_reg(idx, val);
  endtask

  function automatic logic [31:0] rand_target();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return $urandom_range(0, 32'h0020_0000);
    if (r < 75) return $urandom_range(0, 32'h0400_0000);
    if (r < 85) return $urandom_range(0, 32'hFFFE_FFFF);
    if (r < 95) return {16'($urandom_range(0, 40)), 16'h0000};
    return $urandom_range(32'hFFFF_0000, 32'hFFFF_FFFF);  // refused by the block
  endfunction

  function automatic logic [31:0] rand_rate();
    int          r;
    logic [15:0] c;
    r = $urandom_range(0, 99);
    if (r < 25)      c = 16'hFFFF;
    else if (r < 45) c = 16'($urandom_range(1, 255));
    else if (r < 55) c = 16'h0000;
    else if (r < 70) c = 16'($urandom_range(8192, 40000));
    else             c = 16'($urandom_range(1, 65535));
    return {($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'h0000, c};
  endfunction

  function automatic logic [31:0] rand_thresh();
    int          r;
    logic [15:0] c;
    r = $urandom_range(0, 99);
    if (r < 20)      c = 16'h0000;
    else if (r < 35) c = 16'hFFFF;
    else if (r < 60) c = 16'($urandom_range(0, 1000));
    else             c = 16'($urandom_range(0, 65535));
    return {($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'h0000, c};
  endfunction

  initial begin
    int sent;
    int n;
    sb            = new();
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    src_steady    = 1'b0;
    sink_steady   = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings, zero delay: each output is the sample just written
    send_sample(24'h7FFFFF, src_gap());
    send_sample(24'h800000, src_gap());
    send_sample(24'h000000, src_gap());
    send_sample(24'hFFFFFF, src_gap());
    drain_results();

    // fractional delay just past the write slot: read wraps to the top of the store,
    // and without a snap truncation leaves a residual difference
    reg_write(REG_TARGET, 32'h0004_4000);
    reg_write(REG_RATE,   32'h0000_FFFF);
    reg_write(REG_THRESH, 32'h0000_0000);
    for (int i = 0; i < 6; i++)
      send_sample(i[0] ? 24'h800000 : 24'h7FFFFF, src_gap());
    drain_results();

    // largest accepted target, refused targets, frozen glide
    reg_write(REG_TARGET, 32'hFFFE_FFFF);
    reg_write(REG_TARGET, 32'hFFFF_0000);
    reg_write(REG_TARGET, 32'hFFFF_FFFF);
    reg_write(REG_RATE,   32'h0000_0000);
    reg_write(REG_THRESH, 32'h0000_028F);
    repeat (5) send_sample(rand_sample(), src_gap());
    drain_results();

    // upper bits masked, unused register slot ignored
    reg_write(REG_RATE,   32'hFFFF_8000);
    reg_write(REG_THRESH, 32'hABCD_0010);
    reg_write(REG_SPARE,  32'h1234_5678);
    repeat (5) send_sample(rand_sample(), src_gap());
    drain_results();

    // long glide back to zero with the widest snap window
    reg_write(REG_TARGET, 32'h0000_0000);
    reg_write(REG_RATE,   32'h0000_FFFF);
    reg_write(REG_THRESH, 32'h0000_FFFF);
    repeat (5) send_sample(rand_sample(), src_gap());

    sent = 0;
    while (sent < ITEMS) begin
      drain_results();
      src_steady  = ($urandom_range(0, 5) == 0);
      sink_steady = ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 2) != 0) reg_write(REG_TARGET, rand_target());
      if ($urandom_range(0, 2) != 0) reg_write(REG_RATE, rand_rate());
      if ($urandom_range(0, 2) != 0) reg_write(REG_THRESH, rand_thresh());
      n = $urandom_range(20, 120);
      repeat (n) send_sample(rand_sample(), src_gap());
      sent += n;
    end
    drain_results();
    repeat (20) @(posedge clk);

    if (sb.errors == 0) $display("Verification passed");
    else                $display("Verification failed");
    $finish;
  end

endmodule
